>>> sv/mfrp_pkg.sv
// ----------------------------------------------------------------------------
// mfrp_pkg
// Shared constants, configuration types and the binomial helper for the
// mean-field rule polynomial unit.
// ----------------------------------------------------------------------------
`default_nettype none

package mfrp_pkg;

  // Default values for the top-level parameters.
  localparam int unsigned DEF_MAX_NEIGHBOURHOOD = 9;
  localparam int unsigned DEF_FRACTION_BITS     = 16;

  // Configuration port geometry.
  localparam int unsigned CFG_W     = 4;
  localparam int unsigned CFG_IDX_W = 3;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SURVIVE_LOW,
    CFG_SURVIVE_HIGH,
    CFG_BIRTH_LOW,
    CFG_BIRTH_HIGH,
    CFG_NEIGHBOURHOOD
  } cfg_idx_e;

  // Reset values of the configuration registers (Conway's rule, Moore).
  localparam logic [CFG_W-1:0] RST_SURVIVE_LOW   = 4'd2;
  localparam logic [CFG_W-1:0] RST_SURVIVE_HIGH  = 4'd3;
  localparam logic [CFG_W-1:0] RST_BIRTH_LOW     = 4'd3;
  localparam logic [CFG_W-1:0] RST_BIRTH_HIGH    = 4'd3;
  localparam logic [CFG_W-1:0] RST_NEIGHBOURHOOD = 4'd9;

  // The rule as held in the configuration registers.
  typedef struct packed {
    logic [CFG_W-1:0] survive_low;
    logic [CFG_W-1:0] survive_high;
    logic [CFG_W-1:0] birth_low;
    logic [CFG_W-1:0] birth_high;
    logic [CFG_W-1:0] neighbourhood;
  } cfg_t;

  // Binomial coefficient C(m,k) built from Pascal's triangle. Only ever
  // called with elaboration-time arguments, so it folds to a constant.
  function automatic int unsigned binom(input int m, input int k);
    int unsigned row [32];
    int          i;
    int          j;
    if (k < 0 || m < 0 || k > m || m > 31) begin
      return 0;
    end
    for (i = 0; i < 32; i++) begin
      row[i] = 0;
    end
    row[0] = 1;
    for (i = 1; i <= m; i++) begin
      for (j = i; j >= 1; j--) begin
        row[j] = row[j] + row[j-1];
      end
    end
    return row[k];
  endfunction

endpackage

`default_nettype wire

>>> sv/mfrp_coef.sv
// ----------------------------------------------------------------------------
// mfrp_coef
// Turns the rule registers into merged polynomial coefficients and the
// derivative weights a*coef and (n-a)*coef, one set per power of p.
// ----------------------------------------------------------------------------
`default_nettype none

module mfrp_coef #(
  parameter int unsigned MAX_NEIGHBOURHOOD = mfrp_pkg::DEF_MAX_NEIGHBOURHOOD,
  parameter int unsigned NW = $clog2(MAX_NEIGHBOURHOOD + 1),
  parameter int unsigned CW = MAX_NEIGHBOURHOOD + 1,
  parameter int unsigned WW = CW + NW
) (
  input  wire logic          clk_i,
  input  wire mfrp_pkg::cfg_t cfg_i,
  output logic [NW-1:0]      n_eff_o,
  output logic [CW-1:0]      coef_o [MAX_NEIGHBOURHOOD+1],
  output logic [WW-1:0]      wa_o   [MAX_NEIGHBOURHOOD+1],
  output logic [WW-1:0]      wb_o   [MAX_NEIGHBOURHOOD+1]
);

  localparam int unsigned MAXN = MAX_NEIGHBOURHOOD;

  logic [NW-1:0] n_eff_d, n_eff_q;
  logic [CW-1:0] coef_d [MAXN+1];
  logic [CW-1:0] coef_q [MAXN+1];
  logic [WW-1:0] wa_d   [MAXN+1];
  logic [WW-1:0] wa_q   [MAXN+1];
  logic [WW-1:0] wb_d   [MAXN+1];
  logic [WW-1:0] wb_q   [MAXN+1];

  always_comb begin
    logic [CW-1:0] sv;
    logic [CW-1:0] bv;
    logic [CW-1:0] c;
    logic [NW-1:0] b;
    logic          surv_hit;
    logic          birth_hit;

    // Neighbourhood size clamped to 1..MAX.
    if (cfg_i.neighbourhood == '0) begin
      n_eff_d = NW'(1);
    end else if (cfg_i.neighbourhood > mfrp_pkg::CFG_W'(MAXN)) begin
      n_eff_d = NW'(MAXN);
    end else begin
      n_eff_d = NW'(cfg_i.neighbourhood);
    end

    for (int a = 0; a <= int'(MAXN); a++) begin
      sv = '0;
      bv = '0;
      for (int m = 0; m < int'(MAXN); m++) begin
        if (n_eff_d == NW'(m + 1)) begin
          sv = CW'(mfrp_pkg::binom(m, a - 1));
          bv = CW'(mfrp_pkg::binom(m, a));
        end
      end
      // A survival count v lands on p^(v+1); a birth count v on p^v.
      surv_hit = 1'b0;
      if (a >= 1) begin
        surv_hit = ({1'b0, cfg_i.survive_low} <= 5'(a - 1)) &&
                   (5'(a - 1) <= {1'b0, cfg_i.survive_high}) &&
                   (NW'(a) <= n_eff_d);
      end
      birth_hit = ({1'b0, cfg_i.birth_low} <= 5'(a)) &&
                  (5'(a) <= {1'b0, cfg_i.birth_high}) &&
                  (NW'(a) < n_eff_d);
      c = (surv_hit ? sv : '0) + (birth_hit ? bv : '0);
      if (NW'(a) <= n_eff_d) begin
        b = n_eff_d - NW'(a);
      end else begin
        b = '0;
      end
      coef_d[a] = c;
      wa_d[a]   = WW'(c) * WW'(a);
      wb_d[a]   = WW'(c) * WW'(b);
    end
  end

  // Refreshed every cycle; the user must see that the rule only changes while the pipeline is empty (unchecked).
  always_ff @(posedge clk_i) begin
    n_eff_q <= n_eff_d;
    for (int a = 0; a <= int'(MAXN); a++) begin
      coef_q[a] <= coef_d[a];
      wa_q[a]   <= wa_d[a];
      wb_q[a]   <= wb_d[a];
    end
  end

  assign n_eff_o = n_eff_q;
  assign coef_o  = coef_q;
  assign wa_o    = wa_q;
  assign wb_o    = wb_q;

endmodule

`default_nettype wire

>>> sv/mean_field_rule_polynomial_unit.sv
// ----------------------------------------------------------------------------
// mean_field_rule_polynomial_unit
// Mean-field next density f(p) and slope f'(p) of a life-like automaton rule.
// ----------------------------------------------------------------------------
//
//   channel   | signals                                   | direction
//   ----------+-------------------------------------------+----------
//   config    | cfg_we_i, cfg_idx_i, cfg_data_i           | in
//   density   | in_valid_i, in_ready_o, density_i         | in
//   result    | out_valid_o, out_ready_i, next_density_o, | out
//             | slope_o                                   |
//
// A transaction may enter every cycle unless a stalled output holds the
// pipeline back. The density is captured in the first power stage; after
// it come the chain of MAX_NEIGHBOURHOOD - 1 multiplier stages that build the
// powers of p and of 1-p, the term products, the coefficient weighting, two
// adder stages and the saturating output register.
// Reset clears the stage valid bits and loads the rule registers with the
// Conway rule; there is no clearing pass. Every stage has its own ready, so a
// stalled output holds only the stages behind it that are full, and bubbles
// are squeezed out; nothing is lost or repeated.
//
`default_nettype none

module mean_field_rule_polynomial_unit #(
  parameter int unsigned MAX_NEIGHBOURHOOD = mfrp_pkg::DEF_MAX_NEIGHBOURHOOD,
  parameter int unsigned FRACTION_BITS     = mfrp_pkg::DEF_FRACTION_BITS
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // Configuration write port.
  input  wire logic                                 cfg_we_i,
  input  wire logic [mfrp_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [mfrp_pkg::CFG_W-1:0]           cfg_data_i,
  // Density channel.
  input  wire logic                                 in_valid_i,
  output logic                                      in_ready_o,
  input  wire logic [FRACTION_BITS:0]               density_i,
  // Result channel.
  output logic                                      out_valid_o,
  input  wire logic                                 out_ready_i,
  output logic [FRACTION_BITS:0]                    next_density_o,
  output logic signed [FRACTION_BITS+5:0]           slope_o
);

  localparam int unsigned MAXN = MAX_NEIGHBOURHOOD;
  localparam int unsigned F    = FRACTION_BITS;
  localparam int unsigned DW   = F + 1;           // density width
  localparam int unsigned SOW  = F + 6;           // slope output width
  localparam int unsigned PRW  = 2 * DW;          // raw product width
  localparam int unsigned NW   = $clog2(MAXN + 1);
  localparam int unsigned CW   = MAXN + 1;        // merged coefficient
  localparam int unsigned WW   = CW + NW;         // derivative weight
  localparam int unsigned VT   = CW + DW;         // one weighted value term
  localparam int unsigned SPW  = WW + DW + 1;     // one signed slope term
  localparam int unsigned LG   = $clog2(MAXN + 2);
  localparam int unsigned SVW  = VT + LG;         // value sum
  localparam int unsigned SSW  = SPW + LG;        // slope sum
  localparam int unsigned GS   = 4;               // terms per adder group
  localparam int unsigned NG   = (MAXN + GS) / GS;

  // Stage map: power stages 0..MAXN-1, then products, weighting, group sums,
  // total and the output register.
  localparam int unsigned ST_T = MAXN;
  localparam int unsigned ST_W = MAXN + 1;
  localparam int unsigned ST_G = MAXN + 2;
  localparam int unsigned ST_S = MAXN + 3;
  localparam int unsigned ST_O = MAXN + 4;
  localparam int unsigned NS   = MAXN + 5;

  localparam logic [DW-1:0]         ONE    = {1'b1, {F{1'b0}}};
  localparam logic [PRW-1:0]        HALF   = PRW'(1) << (F - 1);
  localparam logic signed [SOW-1:0] SL_MAX = SOW'(longint'(16) << F);
  localparam logic signed [SSW-1:0] SUM_HI = SSW'(longint'(16) << F);
  localparam logic signed [SSW-1:0] SUM_LO = -SUM_HI;

  // Scaled product rounded to nearest, ties upward.
  function automatic logic [DW-1:0] fx_mul(input logic [DW-1:0] x,
                                           input logic [DW-1:0] y);
    logic [PRW-1:0] pr;
    pr = PRW'(x) * PRW'(y) + HALF;
    return pr[F +: DW];
  endfunction

  // --------------------------------------------------------------------------
  // Rule registers
  // --------------------------------------------------------------------------
  mfrp_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.survive_low   <= mfrp_pkg::RST_SURVIVE_LOW;
      cfg_q.survive_high  <= mfrp_pkg::RST_SURVIVE_HIGH;
      cfg_q.birth_low     <= mfrp_pkg::RST_BIRTH_LOW;
      cfg_q.birth_high    <= mfrp_pkg::RST_BIRTH_HIGH;
      cfg_q.neighbourhood <= mfrp_pkg::RST_NEIGHBOURHOOD;
    end else if (cfg_we_i) begin
      unique case (mfrp_pkg::cfg_idx_e'(cfg_idx_i))
        mfrp_pkg::CFG_SURVIVE_LOW:   cfg_q.survive_low   <= cfg_data_i;
        mfrp_pkg::CFG_SURVIVE_HIGH:  cfg_q.survive_high  <= cfg_data_i;
        mfrp_pkg::CFG_BIRTH_LOW:     cfg_q.birth_low     <= cfg_data_i;
        mfrp_pkg::CFG_BIRTH_HIGH:    cfg_q.birth_high    <= cfg_data_i;
        mfrp_pkg::CFG_NEIGHBOURHOOD: cfg_q.neighbourhood <= cfg_data_i;
        default: begin
          // Writes beyond the register list are dropped.
        end
      endcase
    end
  end

  logic [NW-1:0] n_eff;
  logic [CW-1:0] coef [MAXN+1];
  logic [WW-1:0] wa   [MAXN+1];
  logic [WW-1:0] wb   [MAXN+1];

  mfrp_coef #(
    .MAX_NEIGHBOURHOOD (MAXN),
    .NW                (NW),
    .CW                (CW),
    .WW                (WW)
  ) u_coef (
    .clk_i   (clk_i),
    .cfg_i   (cfg_q),
    .n_eff_o (n_eff),
    .coef_o  (coef),
    .wa_o    (wa),
    .wb_o    (wb)
  );

  // --------------------------------------------------------------------------
  // Stage flow control: a stage loads when it is empty or its contents move on.
  // --------------------------------------------------------------------------
  logic [NS-1:0] vld_q;
  logic [NS:0]   adv;

  always_comb begin
    adv[NS] = out_ready_i;
    for (int s = int'(NS) - 1; s >= 0; s--) begin
      adv[s] = !vld_q[s] || adv[s+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int s = 1; s < int'(NS); s++) begin
        if (adv[s]) begin
          vld_q[s] <= vld_q[s-1];
        end
      end
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = vld_q[ST_O];

  // --------------------------------------------------------------------------
  // Power stages: stage s holds p^0..p^(s+1) and the same powers of q = 1-p.
  // --------------------------------------------------------------------------
  logic [DW-1:0] p_in, q_in;
  logic [DW-1:0] pw_q [MAXN][MAXN+1];
  logic [DW-1:0] qw_q [MAXN][MAXN+1];
  logic [DW-1:0] pmul [1:MAXN-1];
  logic [DW-1:0] qmul [1:MAXN-1];

  // Densities above one count as exactly one.
  assign p_in = (density_i > ONE) ? ONE : density_i;
  assign q_in = ONE - p_in;

  always_comb begin
    for (int s = 1; s < int'(MAXN); s++) begin
      pmul[s] = fx_mul(pw_q[s-1][s], pw_q[s-1][1]);
      qmul[s] = fx_mul(qw_q[s-1][s], qw_q[s-1][1]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      for (int j = 0; j <= int'(MAXN); j++) begin
        pw_q[0][j] <= (j == 1) ? p_in : ONE;
        qw_q[0][j] <= (j == 1) ? q_in : ONE;
      end
    end
    for (int s = 1; s < int'(MAXN); s++) begin
      if (adv[s]) begin
        for (int j = 0; j <= int'(MAXN); j++) begin
          pw_q[s][j] <= (j == s + 1) ? pmul[s] : pw_q[s-1][j];
          qw_q[s][j] <= (j == s + 1) ? qmul[s] : qw_q[s-1][j];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Term products: p^a q^b, p^(a-1) q^b and p^a q^(b-1) with b = n - a.
  // --------------------------------------------------------------------------
  logic [DW-1:0] tv_d [MAXN+1];
  logic [DW-1:0] tp_d [MAXN+1];
  logic [DW-1:0] tq_d [MAXN+1];
  logic [DW-1:0] tv_q [MAXN+1];
  logic [DW-1:0] tp_q [MAXN+1];
  logic [DW-1:0] tq_q [MAXN+1];

  always_comb begin
    logic [NW-1:0] bi;
    logic [NW-1:0] bm;
    for (int a = 0; a <= int'(MAXN); a++) begin
      if (NW'(a) <= n_eff) begin
        bi = n_eff - NW'(a);
      end else begin
        bi = '0;
      end
      bm = (bi == '0) ? '0 : bi - NW'(1);
      tv_d[a] = fx_mul(pw_q[MAXN-1][a], qw_q[MAXN-1][bi]);
      tp_d[a] = fx_mul(pw_q[MAXN-1][(a == 0) ? 0 : a - 1], qw_q[MAXN-1][bi]);
      tq_d[a] = fx_mul(pw_q[MAXN-1][a], qw_q[MAXN-1][bm]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[ST_T]) begin
      tv_q <= tv_d;
      tp_q <= tp_d;
      tq_q <= tq_d;
    end
  end

  // --------------------------------------------------------------------------
  // Weighting by the merged coefficients; zero coefficients drop a term.
  // --------------------------------------------------------------------------
  logic [VT-1:0]         val_q [MAXN+1];
  logic signed [SPW-1:0] spt_q [MAXN+1];

  always_ff @(posedge clk_i) begin
    if (adv[ST_W]) begin
      for (int a = 0; a <= int'(MAXN); a++) begin
        val_q[a] <= VT'(coef[a]) * VT'(tv_q[a]);
        spt_q[a] <= $signed({1'b0, (SPW-1)'((SPW-1)'(wa[a]) * (SPW-1)'(tp_q[a]))}) -
                    $signed({1'b0, (SPW-1)'((SPW-1)'(wb[a]) * (SPW-1)'(tq_q[a]))});
      end
    end
  end

  // --------------------------------------------------------------------------
  // Two-level adder tree.
  // --------------------------------------------------------------------------
  logic [SVW-1:0]        gval_d [NG];
  logic signed [SSW-1:0] gsl_d  [NG];
  logic [SVW-1:0]        gval_q [NG];
  logic signed [SSW-1:0] gsl_q  [NG];
  logic [SVW-1:0]        tval_d, tval_q;
  logic signed [SSW-1:0] tsl_d, tsl_q;

  always_comb begin
    for (int g = 0; g < int'(NG); g++) begin
      gval_d[g] = '0;
      gsl_d[g]  = '0;
      for (int i = 0; i < int'(GS); i++) begin
        if (g * int'(GS) + i <= int'(MAXN)) begin
          gval_d[g] = gval_d[g] + SVW'(val_q[g * int'(GS) + i]);
          gsl_d[g]  = gsl_d[g] + SSW'(spt_q[g * int'(GS) + i]);
        end
      end
    end
    tval_d = '0;
    tsl_d  = '0;
    for (int g = 0; g < int'(NG); g++) begin
      tval_d = tval_d + gval_q[g];
      tsl_d  = tsl_d + gsl_q[g];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[ST_G]) begin
      gval_q <= gval_d;
      gsl_q  <= gsl_d;
    end
    if (adv[ST_S]) begin
      tval_q <= tval_d;
      tsl_q  <= tsl_d;
    end
  end

  // --------------------------------------------------------------------------
  // Saturation into the output register.
  // --------------------------------------------------------------------------
  logic [DW-1:0]         nd_d, nd_q;
  logic signed [SOW-1:0] sl_d, sl_q;

  always_comb begin
    nd_d = (tval_q > SVW'(ONE)) ? ONE : DW'(tval_q);
    if (tsl_q > SUM_HI) begin
      sl_d = SL_MAX;
    end else if (tsl_q < SUM_LO) begin
      sl_d = -SL_MAX;
    end else begin
      sl_d = SOW'(tsl_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[ST_O]) begin
      nd_q <= nd_d;
      sl_q <= sl_d;
    end
  end

  assign next_density_o = nd_q;
  assign slope_o        = sl_q;

`ifndef SYNTHESIS
  // The delivered density never exceeds one.
  a_density_bound : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (next_density_o <= ONE)
  ) else $error("next density above one");

  // The delivered slope stays within plus or minus sixteen.
  a_slope_bound : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((slope_o <= SL_MAX) && (slope_o >= -SL_MAX))
  ) else $error("slope outside saturation limits");

  // An empty output register always lets a new transaction in.
  a_ready_when_drained : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !vld_q[ST_O] |-> in_ready_o
  ) else $error("input refused while output stage empty");

  // A stalled result stays valid and its slope stays put until it is taken.
  a_output_held : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(slope_o))
  ) else $error("stalled result changed");
`endif

endmodule

`default_nettype wire
